// ===== src/obvp_pkg.sv =====
// Shared types, constants and lookup functions for the oriented box unit.
package obvp_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int QUAT_FRAC_BITS  = 14;
	localparam int T_DROP_BITS     = 4;
	localparam int C_SHIFT         = 2 * QUAT_FRAC_BITS - T_DROP_BITS - 1;
	localparam int NUM_CORNERS     = 8;
	localparam int NUM_RESULTS     = 14;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [30:0] MIN_HALF_RESET = 31'd12901;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic        [30:0] half_x;
		logic        [30:0] half_y;
		logic        [30:0] half_z;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic signed [15:0] rot_w;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} box_t;

	typedef struct packed {
		logic               is_plane;
		logic        [2:0]  item_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] plane_offset;
		logic               last_result;
	} res_t;

	// Clamped box as held in the queue between front and back.
	typedef struct packed {
		logic        [30:0] ext_x;
		logic        [30:0] ext_y;
		logic        [30:0] ext_z;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} ent_t;

	typedef struct packed {
		logic        is_plane;
		logic [2:0]  idx;
		logic        last;
		logic [30:0] ext_a;
	} ctl_t;

	// Sign bits of each corner, one for +, ordered x, y, z.
	function automatic logic [2:0] corner_signs(input logic [2:0] k);
		logic [2:0] s;
		unique case (k)
			3'd0: s = 3'b000;
			3'd1: s = 3'b100;
			3'd2: s = 3'b101;
			3'd3: s = 3'b001;
			3'd4: s = 3'b010;
			3'd5: s = 3'b110;
			3'd6: s = 3'b111;
			default: s = 3'b011;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] face_axis(input logic [2:0] k);
		logic [1:0] a;
		unique case (k)
			3'd0: a = AXIS_Z;
			3'd1: a = AXIS_Y;
			3'd2: a = AXIS_X;
			3'd3: a = AXIS_X;
			3'd4: a = AXIS_Z;
			default: a = AXIS_Y;
		endcase
		return a;
	endfunction

	function automatic logic face_neg(input logic [2:0] k);
		return (k == 3'd0) || (k == 3'd1) || (k == 3'd3);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/obvp_front.sv =====
// Front end: holds the minimum extent register and clamps incoming boxes.
module obvp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  min_we,
	input  logic [30:0]           min_wdata,
	input  obvp_pkg::box_t        box,
	output obvp_pkg::ent_t        ent
);

	logic [30:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= obvp_pkg::MIN_HALF_RESET;
		end else if (min_we) begin
			min_q <= min_wdata;
		end
	end

	always_comb begin
		ent.ext_x = (box.half_x < min_q) ? min_q : box.half_x;
		ent.ext_y = (box.half_y < min_q) ? min_q : box.half_y;
		ent.ext_z = (box.half_z < min_q) ? min_q : box.half_z;
		ent.qx    = box.rot_x;
		ent.qy    = box.rot_y;
		ent.qz    = box.rot_z;
		ent.qw    = box.rot_w;
		ent.px    = box.pos_x;
		ent.py    = box.pos_y;
		ent.pz    = box.pos_z;
	end

endmodule

// ===== src/obvp_queue.sv =====
// Two-entry queue of clamped boxes between the front and back ends.
module obvp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  obvp_pkg::ent_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output obvp_pkg::ent_t head
);

	obvp_pkg::ent_t mem_q [obvp_pkg::QUEUE_DEPTH];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'(obvp_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/obvp_back.sv =====
// Back end: sequences fourteen results per box through the rotation pipeline.
module obvp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  obvp_pkg::ent_t head,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output obvp_pkg::res_t res
);

	logic       en;
	logic [3:0] cnt_q;
	logic       issue;

	logic signed [32:0] v0;
	logic signed [32:0] v1;
	logic signed [32:0] v2;
	obvp_pkg::ctl_t     ctl0;
	logic [2:0]         sgn;
	logic [2:0]         fidx;
	logic [1:0]         fax;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	obvp_pkg::ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	obvp_pkg::ent_t        box_s1, box_s2, box_s3, box_s4, box_s5;
	logic signed [32:0]    vx_s1, vy_s1, vz_s1;
	logic signed [32:0]    vx_s2, vy_s2, vz_s2;
	logic signed [32:0]    vx_s3, vy_s3, vz_s3;
	logic signed [48:0]    m_s1 [9];
	logic signed [46:0]    tx_s2, ty_s2, tz_s2;
	logic signed [62:0]    c_s3 [6];
	logic signed [42:0]    rx_s4, ry_s4, rz_s4;
	logic signed [31:0]    cx_s5, cy_s5, cz_s5;
	logic signed [31:0]    cx_s6, cy_s6, cz_s6;
	logic signed [63:0]    pr_s6 [3];
	obvp_pkg::res_t        res_s7;

	logic signed [50:0]    tsum [3];
	logic signed [63:0]    cdif [3];
	logic signed [63:0]    rnd [3];
	logic signed [51:0]    osum;

	assign en        = !(v_s7 && res_stall);
	assign issue     = en && head_valid;
	assign pop       = issue && (cnt_q == 4'(obvp_pkg::NUM_RESULTS - 1));
	assign res_valid = v_s7;
	assign res       = res_s7;

	always_comb begin
		sgn  = obvp_pkg::corner_signs(cnt_q[2:0]);
		fidx = 3'(cnt_q - 4'(obvp_pkg::NUM_CORNERS));
		fax  = obvp_pkg::face_axis(fidx);
		ctl0.is_plane = (cnt_q >= 4'(obvp_pkg::NUM_CORNERS));
		ctl0.last     = (cnt_q == 4'(obvp_pkg::NUM_RESULTS - 1));
		ctl0.idx      = ctl0.is_plane ? fidx : cnt_q[2:0];
		unique case (fax)
			obvp_pkg::AXIS_X: ctl0.ext_a = head.ext_x;
			obvp_pkg::AXIS_Y: ctl0.ext_a = head.ext_y;
			default:          ctl0.ext_a = head.ext_z;
		endcase
		if (ctl0.is_plane) begin
			v0 = '0;
			v1 = '0;
			v2 = '0;
			unique case (fax)
				obvp_pkg::AXIS_X: v0 = obvp_pkg::face_neg(fidx)
					? -(33'sd1 <<< obvp_pkg::COORD_FRAC_BITS)
					: (33'sd1 <<< obvp_pkg::COORD_FRAC_BITS);
				obvp_pkg::AXIS_Y: v1 = obvp_pkg::face_neg(fidx)
					? -(33'sd1 <<< obvp_pkg::COORD_FRAC_BITS)
					: (33'sd1 <<< obvp_pkg::COORD_FRAC_BITS);
				default: v2 = obvp_pkg::face_neg(fidx)
					? -(33'sd1 <<< obvp_pkg::COORD_FRAC_BITS)
					: (33'sd1 <<< obvp_pkg::COORD_FRAC_BITS);
			endcase
		end else begin
			v0 = sgn[2] ? $signed({2'b00, head.ext_x}) : -$signed({2'b00, head.ext_x});
			v1 = sgn[1] ? $signed({2'b00, head.ext_y}) : -$signed({2'b00, head.ext_y});
			v2 = sgn[0] ? $signed({2'b00, head.ext_z}) : -$signed({2'b00, head.ext_z});
		end
	end

	always_comb begin
		tsum[0] = 51'(m_s1[0]) - 51'(m_s1[1]) + 51'(m_s1[2]);
		tsum[1] = 51'(m_s1[3]) - 51'(m_s1[4]) + 51'(m_s1[5]);
		tsum[2] = 51'(m_s1[6]) - 51'(m_s1[7]) + 51'(m_s1[8]);
		for (int i = 0; i < 3; i++) begin
			cdif[i] = 64'(c_s3[2 * i]) - 64'(c_s3[2 * i + 1]);
			rnd[i]  = (cdif[i] + (64'sd1 <<< (obvp_pkg::C_SHIFT - 1))) >>> obvp_pkg::C_SHIFT;
		end
		osum = 52'($signed({1'b0, ctl_s6.ext_a}));
		for (int i = 0; i < 3; i++) begin
			osum = osum + 52'((pr_s6[i] + (64'sd1 <<< (obvp_pkg::COORD_FRAC_BITS - 1)))
				>>> obvp_pkg::COORD_FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
		end else if (en) begin
			if (issue) begin
				cnt_q <= pop ? 4'd0 : cnt_q + 4'd1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl0;
			box_s1 <= head;
			vx_s1  <= v0;
			vy_s1  <= v1;
			vz_s1  <= v2;
			m_s1[0] <= 49'(head.qy) * 49'(v2);
			m_s1[1] <= 49'(head.qz) * 49'(v1);
			m_s1[2] <= 49'(head.qw) * 49'(v0);
			m_s1[3] <= 49'(head.qz) * 49'(v0);
			m_s1[4] <= 49'(head.qx) * 49'(v2);
			m_s1[5] <= 49'(head.qw) * 49'(v1);
			m_s1[6] <= 49'(head.qx) * 49'(v1);
			m_s1[7] <= 49'(head.qy) * 49'(v0);
			m_s1[8] <= 49'(head.qw) * 49'(v2);

			ctl_s2 <= ctl_s1;
			box_s2 <= box_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			vz_s2  <= vz_s1;
			tx_s2  <= 47'((tsum[0] + 51'sd8) >>> obvp_pkg::T_DROP_BITS);
			ty_s2  <= 47'((tsum[1] + 51'sd8) >>> obvp_pkg::T_DROP_BITS);
			tz_s2  <= 47'((tsum[2] + 51'sd8) >>> obvp_pkg::T_DROP_BITS);

			ctl_s3 <= ctl_s2;
			box_s3 <= box_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			vz_s3  <= vz_s2;
			c_s3[0] <= 63'(box_s2.qy) * 63'(tz_s2);
			c_s3[1] <= 63'(box_s2.qz) * 63'(ty_s2);
			c_s3[2] <= 63'(box_s2.qz) * 63'(tx_s2);
			c_s3[3] <= 63'(box_s2.qx) * 63'(tz_s2);
			c_s3[4] <= 63'(box_s2.qx) * 63'(ty_s2);
			c_s3[5] <= 63'(box_s2.qy) * 63'(tx_s2);

			ctl_s4 <= ctl_s3;
			box_s4 <= box_s3;
			rx_s4  <= 43'(vx_s3) + 43'(rnd[0]);
			ry_s4  <= 43'(vy_s3) + 43'(rnd[1]);
			rz_s4  <= 43'(vz_s3) + 43'(rnd[2]);

			ctl_s5 <= ctl_s4;
			box_s5 <= box_s4;
			if (ctl_s4.is_plane) begin
				cx_s5 <= obvp_pkg::sat32(64'(rx_s4));
				cy_s5 <= obvp_pkg::sat32(64'(ry_s4));
				cz_s5 <= obvp_pkg::sat32(64'(rz_s4));
			end else begin
				cx_s5 <= obvp_pkg::sat32(64'(rx_s4) + 64'(box_s4.px));
				cy_s5 <= obvp_pkg::sat32(64'(ry_s4) + 64'(box_s4.py));
				cz_s5 <= obvp_pkg::sat32(64'(rz_s4) + 64'(box_s4.pz));
			end

			ctl_s6   <= ctl_s5;
			cx_s6    <= cx_s5;
			cy_s6    <= cy_s5;
			cz_s6    <= cz_s5;
			pr_s6[0] <= 64'(cx_s5) * 64'(box_s5.px);
			pr_s6[1] <= 64'(cy_s5) * 64'(box_s5.py);
			pr_s6[2] <= 64'(cz_s5) * 64'(box_s5.pz);

			res_s7.is_plane     <= ctl_s6.is_plane;
			res_s7.item_index   <= ctl_s6.idx;
			res_s7.last_result  <= ctl_s6.last;
			res_s7.coord_x      <= cx_s6;
			res_s7.coord_y      <= cy_s6;
			res_s7.coord_z      <= cz_s6;
			res_s7.plane_offset <= ctl_s6.is_plane ? obvp_pkg::sat32(64'(osum)) : 32'sd0;
		end
	end

endmodule

// ===== src/oriented_box_vertices_and_planes_unit.sv =====
// An accepted box is written into the queue; its results then pass through the pipeline registers.
// Throughput: one result per cycle while a box is queued and res_stall is low, set by the shared
// rotation pipeline that emits the fourteen results of a box one after another.
// A two-entry queue lets boxes be accepted while results are stalled.
// Reset clears the queue and pipeline and loads the minimum half extent of 12901.
module oriented_box_vertices_and_planes_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            min_we,
	input  logic [30:0]     min_wdata,
	input  logic            box_valid,
	output logic            box_stall,
	input  obvp_pkg::box_t  box,
	output logic            res_valid,
	input  logic            res_stall,
	output obvp_pkg::res_t  res
);

	obvp_pkg::ent_t ent;
	obvp_pkg::ent_t head;
	logic           full;
	logic           not_empty;
	logic           pop;

	assign box_stall = full;

	obvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_we    (min_we),
		.min_wdata (min_wdata),
		.box       (box),
		.ent       (ent)
	);

	obvp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (box_valid && !full),
		.push_data (ent),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	obvp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule
